/* design/multi_led_blink_mode_controller_macros.svh */
// Assertion macros shared by the blink controller RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MULTI_LED_BLINK_MODE_CONTROLLER_MACROS_SVH
`define MULTI_LED_BLINK_MODE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLBMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MLBMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mlbmc_pkg.sv */
// Package of the multi-LED blink mode controller: field widths, command
// and mode codes, and the control struct sent to the LED lanes. No dependencies.
package mlbmc_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned LEVEL_W = 3;

  localparam logic [TIME_W-1:0] EVENT_BLINK_MS = TIME_W'(500);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_SET_LED  = 2'd1,
    CMD_SET_MODE = 2'd2
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL    = 3'd0,
    MODE_EVENT     = 3'd1,
    MODE_FORMAT    = 3'd2,
    MODE_BOOTING   = 3'd3,
    MODE_SD_ERROR  = 3'd4,
    MODE_POWER_OFF = 3'd5,
    MODE_LED_OFF   = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    LANE_IDLE,
    LANE_TICK,
    LANE_SET,
    LANE_NORMAL,
    LANE_EVENT
  } lane_op_e;

  // Broadcast to every lane for the command being executed.
  typedef struct packed {
    lane_op_e          op;
    logic              expire;    // override ran out: re-enter normal bank first
    logic              ovr;       // bank in use for the tick
    logic              alt;       // alternating odd/even pattern in force
    logic [TIME_W-1:0] ev_on;     // event bank settings (new ones on entry)
    logic [TIME_W-1:0] ev_off;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] off_time;
    logic [IDX_W-1:0]  led_index;
  } lane_ctrl_t;

endpackage

/* design/mlbmc_if.sv */
// Valid/ready channel interfaces of the blink controller: command and result.
// Depends on mlbmc_pkg for the field widths.
interface mlbmc_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [mlbmc_pkg::CMD_W-1:0]      command;
  logic [mlbmc_pkg::IDX_W-1:0]      led_index;
  logic [mlbmc_pkg::TIME_W-1:0]     on_time;
  logic [mlbmc_pkg::TIME_W-1:0]     off_time;
  logic [mlbmc_pkg::MODE_W-1:0]     mode_code;
  logic [mlbmc_pkg::TIME_W-1:0]     duration;

  modport source (output valid, command, led_index, on_time, off_time, mode_code,
                  duration, input ready);
  modport sink (input valid, command, led_index, on_time, off_time, mode_code,
                duration, output ready);
endinterface

interface mlbmc_res_if;
  logic                         valid;
  logic                         ready;
  logic [mlbmc_pkg::LEVEL_W-1:0] led_levels;

  modport source (output valid, led_levels, input ready);
  modport sink (input valid, led_levels, output ready);
endinterface

/* design/multi_led_blink_mode_controller.sv */
// Top level of the multi-LED blink mode controller: command register, mode
// control, LED lanes and result register. Depends on mlbmc_pkg, mlbmc_if,
// mlbmc_led_lane and multi_led_blink_mode_controller_macros.svh.
//
//   channel  | dir | interface     | beat carries
//   ---------+-----+---------------+--------------------------------------------
//   cmd_i    | in  | mlbmc_cmd_if  | command, led_index, on/off time, mode, duration
//   res_o    | out | mlbmc_res_if  | led_levels after the command
//
// A command is registered on acceptance and executed once the result register
// is free, when it updates all lanes in parallel and loads the result register:
// one command per cycle sustained while the result side does not stall.
// The command register accepts a new beat whenever it is empty or executing.
// A stalled result holds its register and, through it, the command register.
// Reset clears all mode state, settings, countdowns and levels at once.
`include "multi_led_blink_mode_controller_macros.svh"

module multi_led_blink_mode_controller #(
  parameter int unsigned NUM_LEDS      = 3,
  parameter int unsigned TICK_MS       = 100,
  parameter int unsigned INFINITE_TIME = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mlbmc_cmd_if.sink          cmd_i,
  mlbmc_res_if.source        res_o
);

  localparam int unsigned TW    = mlbmc_pkg::TIME_W;
  localparam int unsigned PAD_W = (NUM_LEDS > mlbmc_pkg::LEVEL_W) ? NUM_LEDS
                                                                   : mlbmc_pkg::LEVEL_W;
  localparam logic [TW-1:0] TICK = TW'(TICK_MS);
  localparam logic [TW-1:0] INF  = TW'(INFINITE_TIME);

  // Command register.
  logic                          cmd_valid_q, cmd_valid_d;
  logic [mlbmc_pkg::CMD_W-1:0]   command_q;
  logic [mlbmc_pkg::IDX_W-1:0]   led_index_q;
  logic [TW-1:0]                 on_time_q, off_time_q, duration_q;
  logic [mlbmc_pkg::MODE_W-1:0]  mode_code_q;
  logic                          accept, advance;

  // Mode state.
  logic          ovr_q, ovr_d, alt_q, alt_d;
  logic [TW-1:0] time_q, time_d, ev_on_q, ev_on_d, ev_off_q, ev_off_d;

  // Result register.
  logic                           res_valid_q, res_valid_d;
  logic [mlbmc_pkg::LEVEL_W-1:0]  res_levels_q;

  mlbmc_pkg::lane_ctrl_t ctrl;
  logic [NUM_LEDS-1:0]   lvl_next;
  logic [PAD_W-1:0]      lvl_pad;

  assign advance     = cmd_valid_q && (!res_valid_q || res_o.ready);
  assign cmd_i.ready = !cmd_valid_q || advance;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign cmd_valid_d = accept || (cmd_valid_q && !advance);
  assign res_valid_d = advance || (res_valid_q && !res_o.ready);

  always_comb begin
    ovr_d          = ovr_q;
    alt_d          = alt_q;
    time_d         = time_q;
    ev_on_d        = ev_on_q;
    ev_off_d       = ev_off_q;
    ctrl.op        = mlbmc_pkg::LANE_IDLE;
    ctrl.expire    = 1'b0;
    ctrl.ovr       = ovr_q;
    ctrl.alt       = alt_q;
    ctrl.ev_on     = ev_on_q;
    ctrl.ev_off    = ev_off_q;
    ctrl.on_time   = on_time_q;
    ctrl.off_time  = off_time_q;
    ctrl.led_index = led_index_q;
    if (advance) begin
      case (command_q)
        mlbmc_pkg::CMD_TICK: begin
          ctrl.op = mlbmc_pkg::LANE_TICK;
          if (ovr_q && time_q != INF) begin
            if (time_q > TICK) begin
              time_d = time_q - TICK;
            end else begin
              ovr_d       = 1'b0;
              alt_d       = 1'b0;
              time_d      = '0;
              ctrl.expire = 1'b1;
            end
          end
          ctrl.ovr = ovr_d;
          ctrl.alt = alt_d;
        end
        mlbmc_pkg::CMD_SET_LED: begin
          ctrl.op = mlbmc_pkg::LANE_SET;
        end
        mlbmc_pkg::CMD_SET_MODE: begin
          case (mode_code_q)
            mlbmc_pkg::MODE_NORMAL: begin
              ovr_d   = 1'b0;
              alt_d   = 1'b0;
              time_d  = duration_q;
              ctrl.op = mlbmc_pkg::LANE_NORMAL;
            end
            mlbmc_pkg::MODE_EVENT, mlbmc_pkg::MODE_FORMAT, mlbmc_pkg::MODE_BOOTING,
            mlbmc_pkg::MODE_SD_ERROR: begin
              ovr_d    = 1'b1;
              alt_d    = 1'b1;
              time_d   = duration_q;
              ev_on_d  = mlbmc_pkg::EVENT_BLINK_MS;
              ev_off_d = mlbmc_pkg::EVENT_BLINK_MS;
              ctrl.op  = mlbmc_pkg::LANE_EVENT;
            end
            mlbmc_pkg::MODE_POWER_OFF, mlbmc_pkg::MODE_LED_OFF: begin
              ovr_d    = 1'b1;
              alt_d    = 1'b1;
              time_d   = duration_q;
              ev_on_d  = '0;
              ev_off_d = INF;
              ctrl.op  = mlbmc_pkg::LANE_EVENT;
            end
            default: begin
            end
          endcase
          ctrl.ev_on  = ev_on_d;
          ctrl.ev_off = ev_off_d;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_lane
    mlbmc_led_lane #(
      .LED_ID  (i),
      .TICK_MS (TICK_MS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .ctrl_i  (ctrl),
      .level_o (lvl_next[i])
    );
  end

  assign lvl_pad = PAD_W'(lvl_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      ovr_q       <= 1'b0;
      alt_q       <= 1'b0;
      time_q      <= '0;
      ev_on_q     <= '0;
      ev_off_q    <= '0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      res_valid_q <= res_valid_d;
      ovr_q       <= ovr_d;
      alt_q       <= alt_d;
      time_q      <= time_d;
      ev_on_q     <= ev_on_d;
      ev_off_q    <= ev_off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      command_q   <= cmd_i.command;
      led_index_q <= cmd_i.led_index;
      on_time_q   <= cmd_i.on_time;
      off_time_q  <= cmd_i.off_time;
      mode_code_q <= cmd_i.mode_code;
      duration_q  <= cmd_i.duration;
    end
    if (advance) begin
      res_levels_q <= lvl_pad[mlbmc_pkg::LEVEL_W-1:0];
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.led_levels = res_levels_q;

  // Every executed command yields exactly one result beat.
  `MLBMC_ASSERT_NEXT(a_exec_gives_result, clk_i, rst_ni, advance, res_valid_q, "executed command produced no result")
  // A waiting command stays in its register until it executes.
  `MLBMC_ASSERT_NEXT(a_cmd_held, clk_i, rst_ni, cmd_valid_q && !advance, cmd_valid_q, "pending command was dropped")
  // The alternating pattern is in force exactly while an override is active.
  `MLBMC_ASSERT_NOW(a_alt_with_ovr, clk_i, rst_ni, 1'b1, alt_q == ovr_q, "alternate flag out of step with override")
  // An override without end survives ticks and set-LED commands.
  `MLBMC_ASSERT_NEXT(a_inf_ovr_stays, clk_i, rst_ni, ovr_q && time_q == INF && !(advance && command_q == mlbmc_pkg::CMD_SET_MODE), ovr_q, "infinite override ended")
  // While an override is active, the event bank holds only the blink or the forced-off settings.
  `MLBMC_ASSERT_NOW(a_ev_settings, clk_i, rst_ni, ovr_q, (ev_on_q == mlbmc_pkg::EVENT_BLINK_MS && ev_off_q == mlbmc_pkg::EVENT_BLINK_MS) || (ev_on_q == '0 && ev_off_q == INF), "event bank settings corrupt")

endmodule

/* design/mlbmc_led_lane.sv */
// One LED lane: normal bank settings and countdowns, event countdowns, level.
// Depends on mlbmc_pkg; driven by the control struct from the top level.
module mlbmc_led_lane #(
  parameter int unsigned LED_ID  = 0,
  parameter int unsigned TICK_MS = 100
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  mlbmc_pkg::lane_ctrl_t ctrl_i,
  output logic                  level_o
);

  localparam logic [mlbmc_pkg::TIME_W-1:0] TICK = mlbmc_pkg::TIME_W'(TICK_MS);
  localparam logic IS_ODD  = (LED_ID % 2) == 1;
  localparam logic ADDR_OK = LED_ID < (1 << mlbmc_pkg::IDX_W);
  localparam logic [mlbmc_pkg::IDX_W-1:0] MY_IDX = mlbmc_pkg::IDX_W'(LED_ID);

  logic [mlbmc_pkg::TIME_W-1:0] n_on_set_q, n_on_set_d, n_off_set_q, n_off_set_d;
  logic [mlbmc_pkg::TIME_W-1:0] n_on_cnt_q, n_on_cnt_d, n_off_cnt_q, n_off_cnt_d;
  logic [mlbmc_pkg::TIME_W-1:0] e_on_cnt_q, e_on_cnt_d, e_off_cnt_q, e_off_cnt_d;
  logic                         level_q, level_d;
  logic [mlbmc_pkg::TIME_W-1:0] s_on, s_off, c_on, c_off;

  always_comb begin
    n_on_set_d  = n_on_set_q;
    n_off_set_d = n_off_set_q;
    n_on_cnt_d  = n_on_cnt_q;
    n_off_cnt_d = n_off_cnt_q;
    e_on_cnt_d  = e_on_cnt_q;
    e_off_cnt_d = e_off_cnt_q;
    level_d     = level_q;
    s_on        = ctrl_i.ovr ? ctrl_i.ev_on : n_on_set_q;
    s_off       = ctrl_i.ovr ? ctrl_i.ev_off : n_off_set_q;
    c_on        = ctrl_i.ovr ? e_on_cnt_q : n_on_cnt_q;
    c_off       = ctrl_i.ovr ? e_off_cnt_q : n_off_cnt_q;
    case (ctrl_i.op)
      mlbmc_pkg::LANE_SET: begin
        if (ADDR_OK && ctrl_i.led_index == MY_IDX) begin
          n_on_set_d  = ctrl_i.on_time;
          n_off_set_d = ctrl_i.off_time;
          n_on_cnt_d  = ctrl_i.on_time;
          n_off_cnt_d = ctrl_i.off_time;
          if (ctrl_i.on_time != '0) begin
            level_d = 1'b1;
          end else if (ctrl_i.off_time != '0) begin
            level_d = 1'b0;
          end
        end
      end
      mlbmc_pkg::LANE_NORMAL: begin
        if (n_on_set_q != '0) begin
          level_d = 1'b1;
        end else if (n_off_set_q != '0) begin
          level_d = 1'b0;
        end
      end
      mlbmc_pkg::LANE_EVENT: begin
        e_on_cnt_d  = ctrl_i.ev_on;
        e_off_cnt_d = ctrl_i.ev_off;
        if (ctrl_i.ev_on != '0) begin
          level_d = IS_ODD;
        end else if (ctrl_i.ev_off != '0) begin
          level_d = 1'b0;
        end
      end
      mlbmc_pkg::LANE_TICK: begin
        // An expiring override re-enters the normal bank, then the tick runs on it.
        if (ctrl_i.expire) begin
          if (n_on_set_q != '0) begin
            level_d = 1'b1;
          end else if (n_off_set_q != '0) begin
            level_d = 1'b0;
          end
        end
        if (s_on != '0 && s_off != '0) begin
          if (c_on > TICK) begin
            c_on = c_on - TICK;
          end else if (c_on != '0) begin
            c_on    = '0;
            level_d = ctrl_i.alt ? !IS_ODD : 1'b0;
          end else if (c_off > TICK) begin
            c_off = c_off - TICK;
          end else begin
            c_on    = s_on;
            c_off   = s_off;
            level_d = ctrl_i.alt ? IS_ODD : 1'b1;
          end
        end
        if (ctrl_i.ovr) begin
          e_on_cnt_d  = c_on;
          e_off_cnt_d = c_off;
        end else begin
          n_on_cnt_d  = c_on;
          n_off_cnt_d = c_off;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_on_set_q  <= '0;
      n_off_set_q <= '0;
      n_on_cnt_q  <= '0;
      n_off_cnt_q <= '0;
      e_on_cnt_q  <= '0;
      e_off_cnt_q <= '0;
      level_q     <= 1'b0;
    end else if (en_i) begin
      n_on_set_q  <= n_on_set_d;
      n_off_set_q <= n_off_set_d;
      n_on_cnt_q  <= n_on_cnt_d;
      n_off_cnt_q <= n_off_cnt_d;
      e_on_cnt_q  <= e_on_cnt_d;
      e_off_cnt_q <= e_off_cnt_d;
      level_q     <= level_d;
    end
  end

  assign level_o = level_d;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the multi-LED blink mode controller: directed table plus random
// commands, each result beat compared with typed table levels or a behavioral model of the LED levels.
// Depends on mlbmc_pkg, mlbmc_if and the multi_led_blink_mode_controller RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CMD_W   = mlbmc_pkg::CMD_W;
  localparam int unsigned IDX_W   = mlbmc_pkg::IDX_W;
  localparam int unsigned TIME_W  = mlbmc_pkg::TIME_W;
  localparam int unsigned MODE_W  = mlbmc_pkg::MODE_W;
  localparam int unsigned LEVEL_W = mlbmc_pkg::LEVEL_W;

  localparam mlbmc_pkg::cmd_e  CMD_TICK       = mlbmc_pkg::CMD_TICK;
  localparam mlbmc_pkg::cmd_e  CMD_SET_LED    = mlbmc_pkg::CMD_SET_LED;
  localparam mlbmc_pkg::cmd_e  CMD_SET_MODE   = mlbmc_pkg::CMD_SET_MODE;
  localparam mlbmc_pkg::mode_e MODE_NORMAL    = mlbmc_pkg::MODE_NORMAL;
  localparam mlbmc_pkg::mode_e MODE_EVENT     = mlbmc_pkg::MODE_EVENT;
  localparam mlbmc_pkg::mode_e MODE_FORMAT    = mlbmc_pkg::MODE_FORMAT;
  localparam mlbmc_pkg::mode_e MODE_BOOTING   = mlbmc_pkg::MODE_BOOTING;
  localparam mlbmc_pkg::mode_e MODE_SD_ERROR  = mlbmc_pkg::MODE_SD_ERROR;
  localparam mlbmc_pkg::mode_e MODE_POWER_OFF = mlbmc_pkg::MODE_POWER_OFF;
  localparam mlbmc_pkg::mode_e MODE_LED_OFF   = mlbmc_pkg::MODE_LED_OFF;
  localparam logic [TIME_W-1:0] EVENT_BLINK_MS = mlbmc_pkg::EVENT_BLINK_MS;

  localparam int unsigned NUM_LEDS     = 3;
  localparam int unsigned TICK_MS      = 100;
  localparam logic [15:0] INFINITE_MS  = 16'hFFFF;
  localparam int unsigned RAND_ITEMS   = 900;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PRESSURE_AT  = 300;
  localparam int unsigned PRESSURE_LEN = 400;
  localparam int unsigned PHASE_LEN    = 150;
  localparam int unsigned DUE_DEPTH    = 16;

  // Codes outside the defined ranges; the block must ignore them.
  localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam logic [IDX_W-1:0]  IDX_OUT     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   led_index;
    logic [TIME_W-1:0]  on_time;
    logic [TIME_W-1:0]  off_time;
    logic [MODE_W-1:0]  mode_code;
    logic [TIME_W-1:0]  duration;
  } cmd_beat_t;

  typedef struct packed {
    cmd_beat_t          beat;
    logic               typed;
    logic [LEVEL_W-1:0] levels;
  } directed_row_t;

  localparam int unsigned NUM_DIRECTED = 26;
  localparam directed_row_t DIRECTED[NUM_DIRECTED] = '{
    '{'{CMD_TICK,     2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b1, 3'b000},
    '{'{CMD_UNUSED,   IDX_OUT, 16'hFFFF,  16'hFFFF,  MODE_UNUSED,    16'hFFFF},  1'b1, 3'b000},
    '{'{CMD_SET_LED,  2'd0,    16'd300,   16'd200,   MODE_NORMAL,    16'd0},     1'b1, 3'b001},
    '{'{CMD_SET_LED,  IDX_OUT, 16'hFFFF,  16'hFFFF,  MODE_NORMAL,    16'd0},     1'b1, 3'b001},
    '{'{CMD_SET_LED,  2'd2,    16'hFFFF,  16'hFFFF,  MODE_NORMAL,    16'd0},     1'b1, 3'b101},
    '{'{CMD_SET_LED,  2'd1,    16'd0,     16'hFFFF,  MODE_NORMAL,    16'd0},     1'b1, 3'b101},
    '{'{CMD_TICK,     2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000},
    '{'{CMD_TICK,     2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000},
    '{'{CMD_TICK,     2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000},
    '{'{CMD_TICK,     2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000},
    '{'{CMD_TICK,     2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000},
    '{'{CMD_SET_MODE, 2'd0,    16'd0,     16'd0,     MODE_EVENT,     16'd300},   1'b1, 3'b010},
    '{'{CMD_TICK,     2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000},
    '{'{CMD_TICK,     2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000},
    '{'{CMD_TICK,     2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000},
    '{'{CMD_SET_MODE, 2'd0,    16'd0,     16'd0,     MODE_BOOTING,   16'hFFFF},  1'b1, 3'b010},
    '{'{CMD_SET_MODE, 2'd0,    16'd0,     16'd0,     MODE_UNUSED,    16'd0},     1'b1, 3'b010},
    '{'{CMD_SET_MODE, 2'd0,    16'd0,     16'd0,     MODE_POWER_OFF, 16'hFFFF},  1'b1, 3'b000},
    '{'{CMD_TICK,     2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000},
    '{'{CMD_SET_LED,  2'd1,    16'd100,   16'd100,   MODE_NORMAL,    16'd0},     1'b1, 3'b010},
    '{'{CMD_SET_MODE, 2'd0,    16'd0,     16'd0,     MODE_LED_OFF,   16'd0},     1'b1, 3'b000},
    '{'{CMD_TICK,     2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000},
    '{'{CMD_SET_MODE, 2'd0,    16'd0,     16'd0,     MODE_FORMAT,    16'd100},   1'b0, 3'b000},
    '{'{CMD_SET_MODE, 2'd0,    16'd0,     16'd0,     MODE_SD_ERROR,  16'd1000},  1'b0, 3'b000},
    '{'{CMD_SET_MODE, 2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000},
    '{'{CMD_SET_LED,  2'd0,    16'd0,     16'd0,     MODE_NORMAL,    16'd0},     1'b0, 3'b000}
  };

  logic clk_i;
  logic rst_ni;

  mlbmc_cmd_if cmd_ch ();
  mlbmc_res_if res_ch ();

  multi_led_blink_mode_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch)
  );

  // Behavioral copy of the blink state.
  logic [TIME_W-1:0]  nrm_on_set  [NUM_LEDS];
  logic [TIME_W-1:0]  nrm_off_set [NUM_LEDS];
  logic [TIME_W-1:0]  nrm_on_cnt  [NUM_LEDS];
  logic [TIME_W-1:0]  nrm_off_cnt [NUM_LEDS];
  logic [TIME_W-1:0]  ev_on_set;
  logic [TIME_W-1:0]  ev_off_set;
  logic [TIME_W-1:0]  ev_on_cnt   [NUM_LEDS];
  logic [TIME_W-1:0]  ev_off_cnt  [NUM_LEDS];
  logic               in_override;
  logic               alt_pattern;
  logic [TIME_W-1:0]  time_left;
  logic [LEVEL_W-1:0] led_model;

  // Expected levels in acceptance order, kept in a small ring.
  logic [LEVEL_W-1:0] levels_due [DUE_DEPTH];
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned errors;
  int unsigned cycles;
  int unsigned n_tick, n_set_led, n_set_mode, n_ignored, n_expiry;
  bit          steady_phase;
  bit          pressure_done;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [TIME_W-1:0] bank_on(int id);
    return in_override ? ev_on_set : nrm_on_set[id];
  endfunction

  function automatic logic [TIME_W-1:0] bank_off(int id);
    return in_override ? ev_off_set : nrm_off_set[id];
  endfunction

  function automatic void enter_bank();
    for (int id = 0; id < NUM_LEDS; id++) begin
      if (bank_on(id) != '0) begin
        led_model[id] = alt_pattern ? id[0] : 1'b1;
      end else if (bank_off(id) != '0) begin
        led_model[id] = 1'b0;
      end
    end
  endfunction

  function automatic void advance_tick();
    logic [TIME_W-1:0] s_on, s_off, c_on, c_off;
    if (in_override && time_left != INFINITE_MS) begin
      if (time_left > TICK_MS) begin
        time_left = time_left - TIME_W'(TICK_MS);
      end else begin
        in_override = 1'b0;
        alt_pattern = 1'b0;
        time_left   = '0;
        n_expiry++;
        enter_bank();
      end
    end
    for (int id = 0; id < NUM_LEDS; id++) begin
      s_on  = bank_on(id);
      s_off = bank_off(id);
      c_on  = in_override ? ev_on_cnt[id]  : nrm_on_cnt[id];
      c_off = in_override ? ev_off_cnt[id] : nrm_off_cnt[id];
      if (s_on != '0 && s_off != '0) begin
        if (c_on > TICK_MS) begin
          c_on = c_on - TIME_W'(TICK_MS);
        end else if (c_on != '0) begin
          c_on = '0;
          led_model[id] = alt_pattern ? ~id[0] : 1'b0;
        end else if (c_off > TICK_MS) begin
          c_off = c_off - TIME_W'(TICK_MS);
        end else begin
          c_on  = s_on;
          c_off = s_off;
          led_model[id] = alt_pattern ? id[0] : 1'b1;
        end
        if (in_override) begin
          ev_on_cnt[id]  = c_on;
          ev_off_cnt[id] = c_off;
        end else begin
          nrm_on_cnt[id]  = c_on;
          nrm_off_cnt[id] = c_off;
        end
      end
    end
  endfunction

  function automatic void apply_mode(logic [MODE_W-1:0] code, logic [TIME_W-1:0] dur);
    logic [TIME_W-1:0] on_ms, off_ms;
    case (code)
      MODE_NORMAL: begin
        in_override = 1'b0;
        alt_pattern = 1'b0;
        time_left   = dur;
        enter_bank();
        return;
      end
      MODE_EVENT, MODE_FORMAT, MODE_BOOTING, MODE_SD_ERROR: begin
        on_ms  = EVENT_BLINK_MS;
        off_ms = EVENT_BLINK_MS;
      end
      MODE_POWER_OFF, MODE_LED_OFF: begin
        on_ms  = '0;
        off_ms = INFINITE_MS;
      end
      default: return;
    endcase
    in_override = 1'b1;
    alt_pattern = 1'b1;
    time_left   = dur;
    ev_on_set   = on_ms;
    ev_off_set  = off_ms;
    for (int id = 0; id < NUM_LEDS; id++) begin
      ev_on_cnt[id]  = on_ms;
      ev_off_cnt[id] = off_ms;
    end
    enter_bank();
  endfunction

  function automatic void store_led(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] on_ms,
                                    logic [TIME_W-1:0] off_ms);
    if (idx >= NUM_LEDS) return;
    nrm_on_set[idx]  = on_ms;
    nrm_off_set[idx] = off_ms;
    nrm_on_cnt[idx]  = on_ms;
    nrm_off_cnt[idx] = off_ms;
    if (on_ms != '0) begin
      led_model[idx] = 1'b1;
    end else if (off_ms != '0) begin
      led_model[idx] = 1'b0;
    end
  endfunction

  function automatic logic [LEVEL_W-1:0] predict_levels(cmd_beat_t b);
    case (b.command)
      CMD_TICK: begin
        n_tick++;
        advance_tick();
      end
      CMD_SET_LED: begin
        n_set_led++;
        store_led(b.led_index, b.on_time, b.off_time);
      end
      CMD_SET_MODE: begin
        n_set_mode++;
        apply_mode(b.mode_code, b.duration);
      end
      default: n_ignored++;
    endcase
    return led_model;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TIME_W-1:0] pick_blink_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return INFINITE_MS;
    if (r < 25) return TIME_W'($urandom());
    return TIME_W'($urandom_range(1, 900));
  endfunction

  function automatic logic [TIME_W-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return INFINITE_MS;
    if (r < 30) return TIME_W'($urandom());
    return TIME_W'($urandom_range(1, 2000));
  endfunction

  // Random command; the fields a command does not use carry noise.
  function automatic cmd_beat_t random_command();
    cmd_beat_t   b;
    int unsigned r;
    b = cmd_beat_t'({$urandom(), $urandom(), $urandom()});
    r = $urandom_range(0, 99);
    if (r < 55) begin
      b.command = CMD_TICK;
    end else if (r < 75) begin
      b.command   = CMD_SET_LED;
      b.led_index = ($urandom_range(0, 19) == 0) ? IDX_OUT : IDX_W'($urandom_range(0, 2));
      b.on_time   = pick_blink_ms();
      b.off_time  = pick_blink_ms();
    end else if (r < 93) begin
      b.command   = CMD_SET_MODE;
      b.mode_code = ($urandom_range(0, 19) == 0) ? MODE_UNUSED
                                                 : MODE_W'($urandom_range(0, 6));
      b.duration  = pick_duration();
    end else begin
      b.command = CMD_UNUSED;
    end
    return b;
  endfunction

  task automatic send_command(cmd_beat_t b, logic typed, logic [LEVEL_W-1:0] typed_levels);
    int unsigned        gap;
    logic [LEVEL_W-1:0] lv;
    gap = steady_phase ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_ch.valid     = 1'b1;
    cmd_ch.command   = b.command;
    cmd_ch.led_index = b.led_index;
    cmd_ch.on_time   = b.on_time;
    cmd_ch.off_time  = b.off_time;
    cmd_ch.mode_code = b.mode_code;
    cmd_ch.duration  = b.duration;
    do @(posedge clk_i); while (!cmd_ch.ready);
    lv = predict_levels(b);
    levels_due[beats_sent % DUE_DEPTH] = typed ? typed_levels : lv;
    beats_sent++;
    steady_phase = ((beats_sent / PHASE_LEN) % 2) == 1;
  endtask

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int unsigned hold;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!pressure_done && beats_sent >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold = PRESSURE_LEN;
      end else begin
        hold = steady_phase ? 0 : pick_gap();
      end
      repeat (hold) begin
        @(negedge clk_i);
        res_ch.ready = 1'b0;
      end
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        res_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    logic [LEVEL_W-1:0] want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (beats_checked == beats_sent) begin
        $error("led_levels beat with no command outstanding: actual %b", res_ch.led_levels);
        errors++;
      end else begin
        want = levels_due[beats_checked % DUE_DEPTH];
        beats_checked++;
        if (res_ch.led_levels !== want) begin
          $error("led_levels mismatch: expected %b, actual %b", want, res_ch.led_levels);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cmd_beat_t   b;
    for (int id = 0; id < NUM_LEDS; id++) begin
      nrm_on_set[id]  = '0;
      nrm_off_set[id] = '0;
      nrm_on_cnt[id]  = '0;
      nrm_off_cnt[id] = '0;
      ev_on_cnt[id]   = '0;
      ev_off_cnt[id]  = '0;
    end
    ev_on_set        = '0;
    ev_off_set       = '0;
    in_override      = 1'b0;
    alt_pattern      = 1'b0;
    time_left        = '0;
    led_model        = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.command   = CMD_TICK;
    cmd_ch.led_index = '0;
    cmd_ch.on_time   = '0;
    cmd_ch.off_time  = '0;
    cmd_ch.mode_code = MODE_NORMAL;
    cmd_ch.duration  = '0;
    rst_ni           = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_command(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].levels);
    end

    for (int i = NUM_DIRECTED; i < RAND_ITEMS; i++) begin
      b = random_command();
      send_command(b, 1'b0, '0);
    end
    @(negedge clk_i);
    cmd_ch.valid = 1'b0;

    wait (beats_checked == beats_sent);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (beats_checked != beats_sent) begin
      $error("%0d led_levels beats never arrived", beats_sent - beats_checked);
      errors++;
    end

    $display("Checked %0d commands: %0d ticks, %0d LED settings, %0d mode changes, %0d ignored.",
             beats_checked, n_tick, n_set_led, n_set_mode, n_ignored);
    $display("Overrides that ran out: %0d; long result stall applied: %0d.",
             n_expiry, pressure_done);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* multi_led_blink_mode_controller.f */
+incdir+design
design/mlbmc_pkg.sv
design/mlbmc_if.sv
design/mlbmc_led_lane.sv
design/multi_led_blink_mode_controller.sv
bench/testbench.sv
